// ===== hdl/cfd_pkg.sv =====
`timescale 1ns / 1ps

package cfd_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_BASELINE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRACTION   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_POLARITY   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_POS = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_NEG = 3'd6;

    // register field widths
    localparam int BASE_W   = 14;
    localparam int FRAC_W   = 16;
    localparam int DELAY_W  = 6;
    localparam int THR_W    = 14;
    localparam int OFFSET_W = 10;

    // result format
    localparam int TIME_W      = 21;
    localparam int TIME_FRAC_W = 8;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MULT   = 6'b000010,
        ST_SUM    = 6'b000100,
        ST_DECIDE = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_OUT    = 6'b100000
    } cfd_state_t;

endpackage

// ===== hdl/constant_fraction_discriminator.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata: sample; tlast: last sample of waveform
// m_axis    out  m_axis_tvalid/tready        tdata: crossing_time; tuser: found
// cfg       in   cfg_valid/cfg_ready         cfg_addr: register index; cfg_data: value
//
// a sample that forms no cfd sum goes straight back to idle, a sample that forms one passes through
// the delay line read, multiply, sum and arm/crossing decision
// a found crossing adds 8 steps of the radix-2 divider and the result load
// a last sample goes back to idle, or through the result load when it has to give the not-found result
// the result sits in an output register, so the next request is taken while it waits
// async active-low reset clears control state; the delay line needs no clearing

module constant_fraction_discriminator #(
    parameter int MAX_DELAY   = 32,
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 14
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                                   s_axis_tlast,

    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [cfd_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,   // [20:0] crossing_time
    output logic                                   m_axis_tuser,   // [0] found

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cfd_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [cfd_pkg::CFG_DATA_W-1:0]         cfg_data
);

    import cfd_pkg::*;

    localparam int AW      = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int IDX_W   = $clog2(MAX_SAMPLES);
    localparam int SUM_W   = SAMPLE_BITS + 18;   // sums scaled by 65536
    localparam int DIFF_W  = SUM_W + 1;
    localparam int REM_W   = DIFF_W + 1;
    localparam int DS_W    = SAMPLE_BITS + 1;    // sample minus baseline
    localparam int CMP_W   = 48;

    // configuration registers
    logic [BASE_W-1:0]   baseline_reg;
    logic [FRAC_W-1:0]   fraction_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic                polarity_reg;
    logic [THR_W-1:0]    threshold_reg;
    logic [OFFSET_W-1:0] offset_pos_reg;
    logic [OFFSET_W-1:0] offset_neg_reg;

    // control state
    cfd_state_t                 state_reg;
    logic [IDX_W-1:0]           sample_index_reg;
    logic [AW-1:0]              wp_reg;
    logic                       armed_reg;
    logic                       reported_reg;
    logic signed [SUM_W-1:0]    prev_sum_reg;
    logic                       hit_reg;
    logic [2:0]                 cnt_reg;
    logic                       out_valid_reg;

    // datapath registers
    logic [SAMPLE_BITS-1:0]     smp_reg;
    logic [IDX_W-1:0]           tidx_reg;
    logic signed [DS_W-1:0]     dhi_reg;
    logic signed [SUM_W-1:0]    prod_reg;
    logic signed [SUM_W-1:0]    s_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [DIFF_W-1:0]          den_reg;
    logic [TIME_FRAC_W-1:0]     q_reg;
    logic                       sat_reg;
    logic                       zero_reg;
    logic                       out_found_reg;
    logic [TIME_W-1:0]          out_time_reg;

    // delay line port
    logic [SAMPLE_BITS-1:0]     ram_rdata;
    logic [AW-1:0]              ram_raddr;
    logic                       ram_we;

    logic                       in_req;
    logic                       out_load;
    logic [SAMPLE_BITS-1:0]     in_sample;
    logic [SAMPLE_BITS-1:0]     base_s;
    logic                       delay_ok;
    logic                       sum_on;
    logic [31:0]                rd32;
    logic [AW-1:0]              wp_inc;

    logic signed [DS_W-1:0]     dsmp;
    logic signed [DS_W-1:0]     ddir;
    logic signed [SUM_W-1:0]    prod_next;
    logic signed [SUM_W-1:0]    s_next;

    logic signed [CMP_W-1:0]    s48;
    logic signed [CMP_W-1:0]    thr48;
    logic                       arm_now;
    logic                       armed_next;
    logic                       hit_now;
    logic [SUM_W-1:0]           num_abs;
    logic signed [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]          den_abs;

    logic [REM_W-1:0]           rem2;
    logic                       step_ge;
    logic [TIME_FRAC_W-1:0]     frac8;
    logic [OFFSET_W-1:0]        off_sel;
    logic [31:0]                time32;

    assign in_sample     = s_axis_tdata[SAMPLE_BITS-1:0];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    // baseline masked to the sample width
    assign base_s = SAMPLE_BITS'(32'(baseline_reg) & ((32'd1 << SAMPLE_BITS) - 32'd1));

    assign delay_ok = (delay_reg != '0) && (32'(delay_reg) <= MAX_DELAY);
    assign sum_on   = !reported_reg && (fraction_reg != '0) && delay_ok
                      && (32'(sample_index_reg) >= 32'(delay_reg) + 32'd1);

    // ring entry written cfd_delay samples ago
    assign rd32 = (32'(wp_reg) >= 32'(delay_reg))
                  ? 32'(wp_reg) - 32'(delay_reg)
                  : 32'(wp_reg) + MAX_DELAY - 32'(delay_reg);
    assign ram_raddr = AW'(rd32);
    assign wp_inc    = (32'(wp_reg) == MAX_DELAY - 1) ? '0 : wp_reg + AW'(1);
    assign ram_we    = in_req && !s_axis_tlast;

    cfd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_DELAY)
    ) u_delay_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (in_sample),
        .re    (in_req),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // S = 65536*(direct - base) - f*(sample - base)
    assign dsmp      = $signed({1'b0, smp_reg}) - $signed({1'b0, base_s});
    assign ddir      = $signed({1'b0, ram_rdata}) - $signed({1'b0, base_s});
    assign prod_next = SUM_W'($signed({1'b0, fraction_reg})) * SUM_W'(dsmp);
    assign s_next    = $signed({dhi_reg[DS_W-1], dhi_reg, 16'b0}) - prod_reg;

    // arming and crossing
    assign s48   = CMP_W'(s_reg);
    assign thr48 = $signed(CMP_W'({threshold_reg, 16'b0}));
    always_comb
    begin
        if (polarity_reg)
        begin
            arm_now = !armed_reg && (s48 < -thr48);
        end
        else
        begin
            arm_now = !armed_reg && (s48 > thr48);
        end
        armed_next = armed_reg || arm_now;
        hit_now    = armed_next && (polarity_reg ? (s_reg > 0) : (s_reg < 0));
    end

    assign num_abs = prev_sum_reg[SUM_W-1] ? SUM_W'(-prev_sum_reg) : SUM_W'(prev_sum_reg);
    assign diff    = DIFF_W'(s_reg) - DIFF_W'(prev_sum_reg);
    assign den_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // one quotient bit per cycle
    assign rem2    = {rem_reg[REM_W-2:0], 1'b0};
    assign step_ge = (rem2 >= REM_W'(den_reg));

    assign frac8   = zero_reg ? '0 : (sat_reg ? '1 : q_reg);
    assign off_sel = polarity_reg ? offset_pos_reg : offset_neg_reg;
    assign time32  = (32'(tidx_reg) << TIME_FRAC_W) + 32'(frac8)
                     - (32'(off_sel) << TIME_FRAC_W);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg   <= '0;
            fraction_reg   <= 16'd32768;
            delay_reg      <= 6'd4;
            polarity_reg   <= 1'b1;
            threshold_reg  <= 14'd10;
            offset_pos_reg <= '0;
            offset_neg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                REG_BASELINE:   baseline_reg   <= cfg_data[BASE_W-1:0];
                REG_FRACTION:   fraction_reg   <= cfg_data[FRAC_W-1:0];
                REG_DELAY:      delay_reg      <= cfg_data[DELAY_W-1:0];
                REG_POLARITY:   polarity_reg   <= cfg_data[0];
                REG_THRESHOLD:  threshold_reg  <= cfg_data[THR_W-1:0];
                REG_OFFSET_POS: offset_pos_reg <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_NEG: offset_neg_reg <= cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and waveform state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_index_reg <= '0;
            wp_reg           <= '0;
            armed_reg        <= 1'b0;
            reported_reg     <= 1'b0;
            prev_sum_reg     <= '0;
            hit_reg          <= 1'b0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_req)
                    begin
                        if (s_axis_tlast)
                        begin
                            // end of waveform
                            sample_index_reg <= '0;
                            armed_reg        <= 1'b0;
                            prev_sum_reg     <= '0;
                            reported_reg     <= 1'b0;
                            hit_reg          <= 1'b0;
                            state_reg        <= reported_reg ? ST_IDLE : ST_OUT;
                        end
                        else
                        begin
                            wp_reg <= wp_inc;
                            if (sample_index_reg != IDX_W'(MAX_SAMPLES - 1))
                            begin
                                sample_index_reg <= sample_index_reg + IDX_W'(1);
                            end
                            state_reg <= sum_on ? ST_MULT : ST_IDLE;
                        end
                    end
                end
                ST_MULT:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    armed_reg    <= armed_next;
                    prev_sum_reg <= s_reg;
                    if (hit_now)
                    begin
                        reported_reg <= 1'b1;
                        hit_reg      <= 1'b1;
                        cnt_reg      <= '0;
                        state_reg    <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            smp_reg  <= in_sample;
            tidx_reg <= IDX_W'(32'(sample_index_reg) - 32'(delay_reg));
        end
        if (state_reg == ST_MULT)
        begin
            dhi_reg  <= ddir;
            prod_reg <= prod_next;
        end
        if (state_reg == ST_SUM)
        begin
            s_reg <= s_next;
        end
        if (state_reg == ST_DECIDE)
        begin
            rem_reg <= REM_W'(num_abs);
            den_reg <= den_abs;
            q_reg   <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            if (cnt_reg == 3'd0)
            begin
                // quotient of 256 or more saturates, zero spread gives zero
                sat_reg  <= (rem_reg >= REM_W'(den_reg));
                zero_reg <= (den_reg == '0);
            end
            rem_reg <= step_ge ? rem2 - REM_W'(den_reg) : rem2;
            q_reg   <= {q_reg[TIME_FRAC_W-2:0], step_ge};
        end
        if (out_load)
        begin
            out_found_reg <= hit_reg;
            out_time_reg  <= hit_reg ? time32[TIME_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - TIME_W){1'b0}}, out_time_reg};

    // a crossing is only reported after arming
    a_report_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        reported_reg |-> armed_reg)
        else $error("crossing reported while not armed");

    // a not-found result carries a zero time
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("not-found result with nonzero time");

    // last sample clears the waveform state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_req && s_axis_tlast) |=> (sample_index_reg == '0 && !armed_reg && !reported_reg))
        else $error("waveform state not cleared by last sample");

    // the divider runs exactly eight steps
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == 3'd7) |=> (state_reg == ST_OUT))
        else $error("divider did not finish after eight steps");

    // no request is taken while a sample is in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_req && !s_axis_tlast && sum_on) |=> (state_reg == ST_MULT && !s_axis_tready))
        else $error("sample pipeline overlap");

endmodule

// ===== hdl/cfd_ram.sv =====
`timescale 1ns / 1ps

module cfd_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read of the entry being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== verif/tb_constant_fraction_discriminator.sv =====
`timescale 1ns / 1ps

module tb_constant_fraction_discriminator;

    import cfd_pkg::*;

    // delay line depth and index ceiling of the default build
    localparam int LINE_DEPTH   = 32;
    localparam int INDEX_CEIL   = 4095;
    // idle cycles after the last expected result before touching registers
    localparam int SETTLE_CYCLES = 32;
    // long output hold-off that backs the block up into its input
    localparam int HOLD_CYCLES  = 400;
    // cycles with no request on any channel before the run is called hung
    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 660;

    // one full register set, fields in register index order
    typedef struct packed {
        logic [13:0] baseline;
        logic [15:0] fraction;
        logic [5:0]  delay;
        logic        positive;
        logic [13:0] threshold;
        logic [9:0]  off_pos;
        logic [9:0]  off_neg;
    } cfd_settings_t;

    localparam cfd_settings_t RESET_SETTINGS = '{
        baseline: 14'd0, fraction: 16'd32768, delay: 6'd4, positive: 1'b1,
        threshold: 14'd10, off_pos: 10'd0, off_neg: 10'd0
    };

    typedef struct packed {
        logic        found;
        logic [20:0] crossing;
    } crossing_t;

    // predicts the crossing result of each waveform and checks what comes out
    class crossing_scoreboard;
        cfd_settings_t regs;
        logic [13:0]   history [LINE_DEPTH];
        int            wr_pos;
        int            idx;
        bit            armed;
        longint        prev_sum;
        bit            reported;
        crossing_t     expected_crossings [$];
        int            mismatches;
        int            results_checked;
        int            crossings_found;

        function new();
            regs = RESET_SETTINGS;
            foreach (history[k])
                history[k] = '0;
            wr_pos          = 0;
            mismatches      = 0;
            results_checked = 0;
            crossings_found = 0;
            restart_waveform();
        endfunction

        function void restart_waveform();
            idx      = 0;
            armed    = 1'b0;
            prev_sum = 0;
            reported = 1'b0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
            case (addr)
                REG_BASELINE:   regs.baseline  = value[13:0];
                REG_FRACTION:   regs.fraction  = value[15:0];
                REG_DELAY:      regs.delay     = value[5:0];
                REG_POLARITY:   regs.positive  = value[0];
                REG_THRESHOLD:  regs.threshold = value[13:0];
                REG_OFFSET_POS: regs.off_pos   = value[9:0];
                REG_OFFSET_NEG: regs.off_neg   = value[9:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [13:0] smp, logic lst);
            longint    direct;
            longint    f;
            longint    base;
            longint    s;
            longint    thr;
            longint    num;
            longint    den;
            longint    frac;
            longint    t;
            logic [9:0] off;
            bit        hit;
            crossing_t want;

            if (lst) begin
                // last sample closes the waveform, not-found if nothing was reported
                if (!reported) begin
                    want.found    = 1'b0;
                    want.crossing = '0;
                    expected_crossings.push_back(want);
                end
                restart_waveform();
                return;
            end

            if (!reported && regs.fraction != 0 && regs.delay >= 1 &&
                regs.delay <= LINE_DEPTH && idx >= int'(regs.delay) + 1) begin
                direct = longint'(history[(wr_pos + LINE_DEPTH - int'(regs.delay)) % LINE_DEPTH]);
                f      = longint'(regs.fraction);
                base   = longint'(regs.baseline);
                s      = direct * 65536 - f * longint'(smp) - base * (65536 - f);
                thr    = longint'(regs.threshold) * 65536;
                if (regs.positive) begin
                    if (!armed && s < -thr)
                        armed = 1'b1;
                    hit = armed && s > 0;
                    off = regs.off_pos;
                end else begin
                    if (!armed && s > thr)
                        armed = 1'b1;
                    hit = armed && s < 0;
                    off = regs.off_neg;
                end
                if (hit) begin
                    // linear interpolation between previous and current sum
                    num = (prev_sum < 0) ? -prev_sum : prev_sum;
                    den = s - prev_sum;
                    if (den < 0)
                        den = -den;
                    frac = 0;
                    if (den != 0) begin
                        frac = (num * 256) / den;
                        if (frac > 255)
                            frac = 255;
                    end
                    t = longint'(idx - int'(regs.delay)) * 256 + frac - longint'(off) * 256;
                    want.found    = 1'b1;
                    want.crossing = t[20:0];
                    expected_crossings.push_back(want);
                    reported = 1'b1;
                end
                prev_sum = s;
            end

            history[wr_pos] = smp;
            wr_pos = (wr_pos + 1) % LINE_DEPTH;
            if (idx < INDEX_CEIL)
                idx++;
        endfunction

        function int pending();
            return expected_crossings.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 100)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic found, logic [20:0] crossing);
            crossing_t want;
            if (expected_crossings.size() == 0) begin
                report_mismatch($sformatf("result with none pending, found=%b time=0x%06h",
                                          found, crossing));
                return;
            end
            want = expected_crossings.pop_front();
            results_checked++;
            if (want.found)
                crossings_found++;
            if (found !== want.found)
                report_mismatch($sformatf("found %b, predicted %b", found, want.found));
            if (crossing !== want.crossing)
                report_mismatch($sformatf("crossing time 0x%06h, predicted 0x%06h",
                                          crossing, want.crossing));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;      // [13:0] sample
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [20:0] crossing_time
    logic        m_axis_tuser;      // [0] found
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    crossing_scoreboard board;
    logic [13:0] wave_buf [$];      // waveform being built, final entry goes out as last
    bit          source_burst = 1'b0;
    bit          sink_burst   = 1'b0;
    bit          hold_output  = 1'b0;
    int          samples_sent   = 0;
    int          waveforms_sent = 0;
    int          quiet_cycles   = 0;

    constant_fraction_discriminator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // hang detection: no request on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else begin
            quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("timeout: no request for %0d cycles, %0d results pending",
                         STALL_LIMIT, board.pending());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result sink: random stall per result, one long hold-off on request
    initial begin : result_sink
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_output)
                stall = HOLD_CYCLES;
            else
                stall = sink_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                hold_output = 1'b0;
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            board.check_result(m_axis_tuser, m_axis_tdata[20:0]);
        end
    end

    // write all seven registers back to back, block must be idle
    task automatic apply_settings(input cfd_settings_t s);
        logic [CFG_DATA_W-1:0] value [7];
        logic [CFG_ADDR_W-1:0] reg_addr [7];
        value    = '{16'(s.baseline), s.fraction, 16'(s.delay), 16'(s.positive),
                     16'(s.threshold), 16'(s.off_pos), 16'(s.off_neg)};
        reg_addr = '{REG_BASELINE, REG_FRACTION, REG_DELAY, REG_POLARITY,
                     REG_THRESHOLD, REG_OFFSET_POS, REG_OFFSET_NEG};
        for (int k = 0; k < 7; k++) begin
            cfg_valid <= 1'b1;
            cfg_addr  <= reg_addr[k];
            cfg_data  <= value[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            board.set_reg(reg_addr[k], value[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // offer one sample after a random gap; valid stays up when the gap is zero
    task automatic send_sample(input logic [13:0] smp, input logic lst);
        int gap;
        gap = source_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, smp};
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_sample(smp, lst);
        samples_sent++;
    endtask

    task automatic send_waveform();
        for (int k = 0; k < wave_buf.size(); k++)
            send_sample(wave_buf[k], k == wave_buf.size() - 1);
        waveforms_sent++;
    endtask

    task automatic add_flat(input int level, input int count);
        repeat (count) wave_buf.push_back(14'(level));
    endtask

    // drop valid, wait out every pending result, then let a possible sum finish
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic cfd_settings_t pick_settings();
        cfd_settings_t s;
        bit extreme;
        extreme = ($urandom_range(0, 4) == 0);
        if (extreme)
            s.baseline = $urandom_range(0, 1) ? 14'h3FFF : 14'd0;
        else
            s.baseline = 14'($urandom_range(0, 16383));
        // fraction zero is out of range but must be survived
        if ($urandom_range(0, 19) == 0)
            s.fraction = 16'd0;
        else if ($urandom_range(0, 4) == 0)
            s.fraction = $urandom_range(0, 1) ? 16'd1 : 16'hFFFF;
        else
            s.fraction = 16'($urandom_range(1, 65535));
        // delay of zero or past the line depth forms no sums
        if ($urandom_range(0, 19) == 0)
            s.delay = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
        else if ($urandom_range(0, 4) == 0)
            s.delay = $urandom_range(0, 1) ? 6'd1 : 6'd32;
        else
            s.delay = 6'($urandom_range(1, 32));
        s.positive = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0)
            s.threshold = $urandom_range(0, 1) ? 14'h3FFF : 14'd0;
        else
            s.threshold = 14'($urandom_range(0, 2000));
        s.off_pos = ($urandom_range(0, 4) == 0) ? 10'h3FF : 10'($urandom_range(0, 1023));
        s.off_neg = ($urandom_range(0, 4) == 0) ? 10'd0 : 10'($urandom_range(0, 1023));
        return s;
    endfunction

    // triangular-ish pulse on a baseline with a little jitter, sometimes cut short
    task automatic make_pulse(input cfd_settings_t s);
        int  lvl;
        int  amp;
        int  start;
        int  rise;
        int  width;
        int  fall;
        int  len;
        int  jitter;
        int  shape;
        int  v;
        bit  up;
        lvl    = ($urandom_range(0, 4) != 0) ? int'(s.baseline) : $urandom_range(0, 16383);
        up     = ($urandom_range(0, 6) != 0) ? s.positive : !s.positive;
        amp    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : $urandom_range(200, 12000);
        start  = $urandom_range(1, 12);
        rise   = $urandom_range(1, 5);
        width  = $urandom_range(0, 6);
        fall   = $urandom_range(1, 12);
        jitter = $urandom_range(0, 3);
        len    = start + rise + width + fall + int'(s.delay) + $urandom_range(1, 20);
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(1, len);
        wave_buf.delete();
        for (int k = 0; k < len; k++) begin
            if (k < start)
                shape = 0;
            else if (k < start + rise)
                shape = amp * (k - start + 1) / rise;
            else if (k < start + rise + width)
                shape = amp;
            else if (k < start + rise + width + fall)
                shape = amp * (start + rise + width + fall - k) / (fall + 1);
            else
                shape = 0;
            v = lvl + (up ? shape : -shape) + $urandom_range(0, 2 * jitter) - jitter;
            if (v < 0)
                v = 0;
            if (v > 16383)
                v = 16383;
            wave_buf.push_back(14'(v));
        end
    endtask

    initial begin : stimulus
        cfd_settings_t cfg_now;
        int random_base;
        int kind;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_addr      <= REG_BASELINE;
        cfg_data      <= '0;
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: lone last sample, a clean step, a short waveform
        wave_buf = '{14'h3FFF};
        send_waveform();
        wave_buf.delete();
        add_flat(0, 5);
        add_flat(16383, 7);
        send_waveform();        // crossing, then two more samples after the result
        wave_buf = '{14'h3FFF, 14'h3FFF, 14'h3FFF, 14'd0};
        send_waveform();        // too short to form a sum
        wait_until_idle();

        // delay of one, zero threshold, full positive offset drives the time negative
        cfg_now = '{baseline: 14'd0, fraction: 16'd32768, delay: 6'd1, positive: 1'b1,
                    threshold: 14'd0, off_pos: 10'h3FF, off_neg: 10'd0};
        apply_settings(cfg_now);
        wave_buf = '{14'd0, 14'd0, 14'h3FFF, 14'h3FFF, 14'h3FFF};
        send_waveform();
        wait_until_idle();

        // fraction zero, then delay zero: no sums, only the not-found result
        cfg_now.fraction = 16'd0;
        apply_settings(cfg_now);
        send_waveform();
        wait_until_idle();
        cfg_now.fraction = 16'd32768;
        cfg_now.delay    = 6'd0;
        apply_settings(cfg_now);
        send_waveform();
        wait_until_idle();

        // negative polarity, largest fraction, interpolation at its largest unsaturated value, full negative offset
        cfg_now = '{baseline: 14'd1, fraction: 16'hFFFF, delay: 6'd1, positive: 1'b0,
                    threshold: 14'd100, off_pos: 10'd0, off_neg: 10'h3FF};
        apply_settings(cfg_now);
        wave_buf = '{14'h3FFF, 14'h3FFF, 14'd0, 14'd0, 14'd0};
        send_waveform();
        wait_until_idle();

        // back-pressure: sink holds off while short waveforms keep coming
        apply_settings(RESET_SETTINGS);
        source_burst = 1'b1;
        hold_output = 1'b1;
        repeat (40) begin
            wave_buf = '{14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383))};
            send_waveform();
        end
        source_burst = 1'b0;
        wait_until_idle();

        // random phases: mostly pulses, some noise and broken waveforms
        random_base = samples_sent;
        while (samples_sent - random_base < RANDOM_ITEMS) begin
            cfg_now = pick_settings();
            apply_settings(cfg_now);
            source_burst = ($urandom_range(0, 3) == 0);
            sink_burst   = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 6)) begin
                kind = $urandom_range(0, 19);
                if (kind < 15)
                    make_pulse(cfg_now);
                else begin
                    wave_buf.delete();
                    repeat ((kind < 18) ? $urandom_range(1, 24) : $urandom_range(1, 2))
                        wave_buf.push_back(14'($urandom_range(0, 16383)));
                end
                send_waveform();
            end
            wait_until_idle();
        end

        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d predicted results never arrived",
                                            board.pending()));
        $display("run covered %0d samples in %0d waveforms, %0d results checked, %0d crossings",
                 samples_sent, waveforms_sent, board.results_checked, board.crossings_found);
        $display("both polarities, extreme registers, disabled sums, short waveforms, back-pressure");
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
